// ===== rtl/cbm_pkg.sv =====
`default_nettype none

package cbm_pkg;

   // counter timing
   localparam int unsigned VISIBLE_LINES   = 240;
   localparam int unsigned CYCLES_PER_STEP = 4;

   localparam logic [8:0] VIS_LINES_C   = 9'(VISIBLE_LINES);
   localparam logic [8:0] CPS_C         = 9'(CYCLES_PER_STEP);
   localparam logic [8:0] CNT_MINUS_ONE = 9'h1FF;

   // item kinds
   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_TICK  = 2'd1;
   localparam logic [1:0] MODE_SYNC  = 2'd2;

   // setting targets
   localparam logic [1:0] TGT_CHR    = 2'd0;
   localparam logic [1:0] TGT_PRG    = 2'd1;
   localparam logic [1:0] TGT_MIRROR = 2'd2;

   typedef struct packed {
      logic [8:0] count;
      logic [8:0] accum;
   } step_in_type;

   typedef struct packed {
      logic [8:0] count;
      logic       underflow;
      logic [8:0] accum;
      logic       accum_ge;
   } step_out_type;

   typedef struct packed {
      logic       set_valid;
      logic [1:0] target;
      logic [2:0] slot;
      logic [8:0] bank;
   } setting_type;

endpackage

`default_nettype wire

// ===== rtl/cartridge_bank_mapper_irq.sv =====
// cartridge bank mapper with irq counter
//
// req channel: one transfer per item; req_mode picks a bus write, a cpu
// cycle tick or a horizontal sync, and only the fields of that kind are used
// rsp channel: one or two transfers per item; rsp_last marks the final one,
// rsp_irq_line is the interrupt level after the whole item
// a bus write to the bank data port with a chr pair command gives two
// settings; every item that sets nothing gives one transfer with
// rsp_set_valid low
// writes, syncs and ticks outside cycle counting go from idle through the
// emit state into the output register; a counting tick adds cycles to the
// 9-bit accumulator and first passes through the calc state, which takes one
// counter step per clock in the single shared step unit until the accumulator
// drops below CYCLES_PER_STEP; a chr pair passes through a second emit state
// req_ready is high only while the sequencer is idle; a new item is taken
// while the previous result still sits in the output register
// when rsp_ready is low, the sequencer holds its pending results and waits
// reset clears all mapper and counter state and empties the output register
`default_nettype none

module cartridge_bank_mapper_irq (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_mode,
   input  wire logic [15:0] req_addr,
   input  wire logic [7:0]  req_data,
   input  wire logic [7:0]  req_cycles,
   input  wire logic [8:0]  req_scanline,
   input  wire logic        req_display_on,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_set_valid,
   output logic [1:0]       rsp_target,
   output logic [2:0]       rsp_slot,
   output logic [8:0]       rsp_bank_number,
   output logic             rsp_irq_line,
   output logic             rsp_last
);
   import cbm_pkg::*;

   // sequencer states
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CALC  = 2'd1;
   localparam logic [1:0] S_EMIT  = 2'd2;
   localparam logic [1:0] S_EMIT2 = 2'd3;

   // bus addresses after masking
   localparam logic [15:0] ADDR_MASK     = 16'hF003;
   localparam logic [15:0] ADDR_BANK_SEL = 16'h8000;
   localparam logic [15:0] ADDR_BANK_DAT = 16'h8001;
   localparam logic [15:0] ADDR_MIRROR   = 16'hA000;
   localparam logic [15:0] ADDR_IRQ_LAT  = 16'hC000;
   localparam logic [15:0] ADDR_IRQ_RLD  = 16'hC001;
   localparam logic [15:0] ADDR_IRQ_OFF  = 16'hE000;
   localparam logic [15:0] ADDR_IRQ_ON   = 16'hE001;

   // bank commands
   localparam logic [3:0] CMD_CHR_PAIR0 = 4'd0;
   localparam logic [3:0] CMD_CHR_PAIR1 = 4'd1;
   localparam logic [3:0] CMD_CHR_A     = 4'd2;
   localparam logic [3:0] CMD_CHR_B     = 4'd3;
   localparam logic [3:0] CMD_CHR_C     = 4'd4;
   localparam logic [3:0] CMD_CHR_D     = 4'd5;
   localparam logic [3:0] CMD_PRG_A     = 4'd6;
   localparam logic [3:0] CMD_PRG_B     = 4'd7;
   localparam logic [3:0] CMD_CHR_ODD1  = 4'd8;
   localparam logic [3:0] CMD_CHR_ODD3  = 4'd9;
   localparam logic [3:0] CMD_PRG_C     = 4'd15;

   logic [1:0]  state_ff, state_in;
   logic [3:0]  cmd_ff, cmd_in;
   logic        prg_swap_ff, prg_swap_in;
   logic        chr_invert_ff, chr_invert_in;
   logic        irq_en_ff, irq_en_in;
   logic        count_cpu_ff, count_cpu_in;
   logic [8:0]  irq_count_ff, irq_count_in;
   logic [8:0]  accum_ff, accum_in;
   logic [7:0]  reload_val_ff, reload_val_in;
   logic        reload_pend_ff, reload_pend_in;
   logic        irq_level_ff, irq_level_in;

   // pending results of the current item
   setting_type res0_ff, res0_in;
   setting_type res1_ff, res1_in;
   logic        two_ff, two_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   setting_type rsp_set_ff, rsp_set_in;
   logic        rsp_irq_ff, rsp_irq_in;
   logic        rsp_last_ff, rsp_last_in;

   step_in_type  step_in;
   step_out_type step_out;

   logic [15:0] addr_masked;
   logic        out_free;
   logic [1:0]  chr_hi;
   logic [8:0]  data_ext;

   // shared count-down / accumulator unit
   cbm_step_unit u_step (
      .step_in  (step_in),
      .step_out (step_out)
   );

   assign step_in.count = irq_count_ff;
   assign step_in.accum = accum_ff;

   assign addr_masked = req_addr & ADDR_MASK;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign chr_hi      = cmd_ff[1:0] - 2'd2;
   assign data_ext    = {1'b0, req_data};

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_set_valid   = rsp_set_ff.set_valid;
   assign rsp_target      = rsp_set_ff.target;
   assign rsp_slot        = rsp_set_ff.slot;
   assign rsp_bank_number = rsp_set_ff.bank;
   assign rsp_irq_line    = rsp_irq_ff;
   assign rsp_last        = rsp_last_ff;

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      prg_swap_in    = prg_swap_ff;
      chr_invert_in  = chr_invert_ff;
      irq_en_in      = irq_en_ff;
      count_cpu_in   = count_cpu_ff;
      irq_count_in   = irq_count_ff;
      accum_in       = accum_ff;
      reload_val_in  = reload_val_ff;
      reload_pend_in = reload_pend_ff;
      irq_level_in   = irq_level_ff;
      res0_in        = res0_ff;
      res1_in        = res1_ff;
      two_in         = two_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_set_in     = rsp_set_ff;
      rsp_irq_in     = rsp_irq_ff;
      rsp_last_in    = rsp_last_ff;

      // output register drains on a transfer
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res0_in  = '0;
               res1_in  = '0;
               two_in   = 1'b0;
               state_in = S_EMIT;
               unique case (req_mode)
                  MODE_WRITE: begin
                     unique case (addr_masked)
                        ADDR_BANK_SEL: begin
                           cmd_in        = req_data[3:0];
                           prg_swap_in   = req_data[6];
                           chr_invert_in = req_data[7];
                        end
                        ADDR_BANK_DAT: begin
                           unique case (cmd_ff)
                              CMD_CHR_PAIR0, CMD_CHR_PAIR1: begin
                                 // two consecutive 1 kB slots
                                 res0_in = '{1'b1, TGT_CHR,
                                             {chr_invert_ff, cmd_ff[0], 1'b0}, data_ext};
                                 res1_in = '{1'b1, TGT_CHR,
                                             {chr_invert_ff, cmd_ff[0], 1'b1},
                                             data_ext + 9'd1};
                                 two_in  = 1'b1;
                              end
                              CMD_CHR_A, CMD_CHR_B, CMD_CHR_C, CMD_CHR_D: begin
                                 res0_in = '{1'b1, TGT_CHR, {!chr_invert_ff, chr_hi},
                                             data_ext};
                              end
                              CMD_PRG_A: begin
                                 res0_in = '{1'b1, TGT_PRG,
                                             prg_swap_ff ? 3'd5 : 3'd4, data_ext};
                              end
                              CMD_PRG_B: begin
                                 res0_in = '{1'b1, TGT_PRG,
                                             prg_swap_ff ? 3'd6 : 3'd5, data_ext};
                              end
                              CMD_CHR_ODD1: begin
                                 res0_in = '{1'b1, TGT_CHR, 3'd1, data_ext};
                              end
                              CMD_CHR_ODD3: begin
                                 res0_in = '{1'b1, TGT_CHR, 3'd3, data_ext};
                              end
                              CMD_PRG_C: begin
                                 res0_in = '{1'b1, TGT_PRG,
                                             prg_swap_ff ? 3'd4 : 3'd6, data_ext};
                              end
                              default: begin
                                 // unused commands set nothing
                              end
                           endcase
                        end
                        ADDR_MIRROR: begin
                           res0_in = '{1'b1, TGT_MIRROR, 3'd0, {8'd0, req_data[0]}};
                        end
                        ADDR_IRQ_LAT: begin
                           reload_val_in = req_data;
                           if (reload_pend_ff) begin
                              irq_count_in = data_ext;
                           end
                        end
                        ADDR_IRQ_RLD: begin
                           reload_pend_in = 1'b1;
                           irq_count_in   = {1'b0, reload_val_ff};
                           count_cpu_in   = req_data[0];
                        end
                        ADDR_IRQ_OFF: begin
                           irq_en_in    = 1'b0;
                           irq_level_in = 1'b0;
                           if (reload_pend_ff) begin
                              irq_count_in = {1'b0, reload_val_ff};
                           end
                        end
                        ADDR_IRQ_ON: begin
                           irq_en_in = 1'b1;
                           if (reload_pend_ff) begin
                              irq_count_in = {1'b0, reload_val_ff};
                           end
                        end
                        default: begin
                           // address not decoded
                        end
                     endcase
                  end
                  MODE_TICK: begin
                     if (count_cpu_ff) begin
                        accum_in = accum_ff + {1'b0, req_cycles};
                        state_in = S_CALC;
                     end
                  end
                  MODE_SYNC: begin
                     if (!count_cpu_ff) begin
                        reload_pend_in = 1'b0;
                        if (req_scanline < VIS_LINES_C && req_display_on) begin
                           irq_count_in = step_out.count;
                           if (step_out.underflow && irq_en_ff) begin
                              reload_pend_in = 1'b1;
                              irq_level_in   = 1'b1;
                           end
                        end
                     end
                  end
                  default: begin
                     // unknown kind changes nothing
                  end
               endcase
            end
         end
         S_CALC: begin
            // one counter step per clock until the accumulator drops below a step
            if (step_out.accum_ge) begin
               accum_in     = step_out.accum;
               irq_count_in = step_out.count;
               if (step_out.underflow && irq_en_ff) begin
                  irq_level_in = 1'b1;
               end
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_set_in   = res0_ff;
               rsp_irq_in   = irq_level_ff;
               rsp_last_in  = !two_ff;
               state_in     = two_ff ? S_EMIT2 : S_IDLE;
            end
         end
         S_EMIT2: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_set_in   = res1_ff;
               rsp_irq_in   = irq_level_ff;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         cmd_ff         <= '0;
         prg_swap_ff    <= 1'b0;
         chr_invert_ff  <= 1'b0;
         irq_en_ff      <= 1'b0;
         count_cpu_ff   <= 1'b0;
         irq_count_ff   <= '0;
         accum_ff       <= '0;
         reload_val_ff  <= '0;
         reload_pend_ff <= 1'b0;
         irq_level_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cmd_ff         <= cmd_in;
         prg_swap_ff    <= prg_swap_in;
         chr_invert_ff  <= chr_invert_in;
         irq_en_ff      <= irq_en_in;
         count_cpu_ff   <= count_cpu_in;
         irq_count_ff   <= irq_count_in;
         accum_ff       <= accum_in;
         reload_val_ff  <= reload_val_in;
         reload_pend_ff <= reload_pend_in;
         irq_level_ff   <= irq_level_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      res0_ff     <= res0_in;
      res1_ff     <= res1_in;
      two_ff      <= two_in;
      rsp_set_ff  <= rsp_set_in;
      rsp_irq_ff  <= rsp_irq_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

`default_nettype wire

// ===== rtl/cbm_step_unit.sv =====
`default_nettype none

module cbm_step_unit (
   input  cbm_pkg::step_in_type  step_in,
   output cbm_pkg::step_out_type step_out
);
   import cbm_pkg::*;

   always_comb begin
      // cycle accumulator compare and subtract
      step_out.accum_ge = (step_in.accum >= CPS_C);
      step_out.accum    = step_in.accum - CPS_C;
      // counter sticks at minus one until reloaded
      if (step_in.count == CNT_MINUS_ONE || step_in.count[8]) begin
         step_out.count     = step_in.count;
         step_out.underflow = 1'b0;
      end else begin
         step_out.count     = step_in.count - 9'd1;
         step_out.underflow = (step_in.count == 9'd0);
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cbm_checker.sv =====
`default_nettype none

module cbm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_set_valid,
   input wire logic [1:0]  rsp_target,
   input wire logic [2:0]  rsp_slot,
   input wire logic [8:0]  rsp_bank_number,
   input wire logic        rsp_irq_line,
   input wire logic        rsp_last
);
   import cbm_pkg::*;

   // busy in the cycle after taking an item
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready stayed high after a transfer");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bank_number)
         && $stable(rsp_slot) && $stable(rsp_irq_line) && $stable(rsp_last))
      else $error("rsp payload changed while stalled");

   // only a chr pair produces a second result, right after the first
   a_pair_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |-> rsp_set_valid && rsp_target == TGT_CHR
         ##1 rsp_valid && rsp_set_valid && rsp_target == TGT_CHR && rsp_last)
      else $error("bad chr pair sequence");

   // empty result is a single zeroed transfer
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_set_valid |-> rsp_last && rsp_target == TGT_CHR
         && rsp_slot == 3'd0 && rsp_bank_number == 9'd0)
      else $error("empty result carries data");

   // mirroring result carries one bit in slot zero
   a_mirror_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_set_valid && rsp_target == TGT_MIRROR |->
         rsp_slot == 3'd0 && rsp_bank_number[8:1] == 8'd0)
      else $error("malformed mirroring result");

endmodule

bind cartridge_bank_mapper_irq cbm_checker u_cbm_checker (.*);

`default_nettype wire
